### rtl/bld_pkg.sv
package bld_pkg;

	localparam int DATA_W      = 64;
	localparam int SIDE_W      = 14;
	localparam int COL_W       = SIDE_W - 2;
	localparam int LEN_W       = 27;
	localparam int BLOCK_W     = 21;
	localparam int COORD_W     = 10;
	localparam int ROW_W       = COORD_W + 2;
	localparam int ADDR_W      = 30;
	localparam int CFG_W       = LEN_W;
	localparam int CFG_IDX_W   = 2;
	localparam int TABLE_SIZE  = 8;
	localparam int TABLE_IDX_W = $clog2(TABLE_SIZE);

	localparam int TABLE_ROWS_DEF   = 8;
	localparam int HEADER_BYTES_DEF = 12;

	localparam logic [BLOCK_W-1:0] BLK_LIMIT [TABLE_SIZE] = '{
		21'h000040, 21'h000100, 21'h000400, 21'h001000,
		21'h004000, 21'h010000, 21'h040000, 21'h100000
	};
	localparam logic [BLOCK_W-1:0] X_MASK [TABLE_SIZE] = '{
		21'h000032, 21'h0000d2, 21'h000392, 21'h000f12,
		21'h003e12, 21'h007e12, 21'h00fe12, 21'h01fe12
	};
	localparam logic [BLOCK_W-1:0] Y_MASK [TABLE_SIZE] = '{
		21'h00000d, 21'h00002d, 21'h00006d, 21'h0000ed,
		21'h0001ed, 21'h0081ed, 21'h0301ed, 21'h0e01ed
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_DATA_LENGTH  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [1:0]         z;
		logic [COL_W-1:0]   w;
	} pos_t;

endpackage

### rtl/bld_pos.sv
module bld_pos import bld_pkg::*; #(
	parameter int TABLE_ROWS = TABLE_ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic               adv,
	input  logic               start_image,
	input  logic [DATA_W-1:0]  row_low_half,
	input  logic [DATA_W-1:0]  row_high_half,
	input  logic [SIDE_W-1:0]  image_width,
	input  logic [SIDE_W-1:0]  image_height,
	input  logic [LEN_W-1:0]   data_length,
	output logic               valid_s1,
	output pos_t               pos_s1,
	output logic [DATA_W-1:0]  low_s1,
	output logic [DATA_W-1:0]  high_s1
);

	logic [BLOCK_W-1:0]     block_counter_q;
	logic [1:0]             row_in_block_q;
	logic                   halted_q;

	logic [BLOCK_W-1:0]     bc;
	logic [1:0]             z;
	logic                   hlt;
	logic [BLOCK_W-1:0]     blocks;
	logic                   found;
	logic [TABLE_IDX_W-1:0] sel;
	logic [COORD_W-1:0]     xs [TABLE_SIZE];
	logic [COORD_W-1:0]     ys [TABLE_SIZE];
	logic [COORD_W-1:0]     x;
	logic [COORD_W-1:0]     y;
	logic [COL_W-1:0]       w;
	logic [COL_W-1:0]       h;
	logic                   fail;
	logic                   emit;
	logic [BLOCK_W-1:0]     bc_next;
	logic [1:0]             z_next;
	logic                   hlt_next;

	// pack the bits of v picked by m toward bit 0
	function automatic logic [COORD_W-1:0] gather(
		input logic [BLOCK_W-1:0] v,
		input logic [BLOCK_W-1:0] m
	);
		logic [COORD_W-1:0]               res;
		logic [$clog2(COORD_W+1)-1:0]     k;
		res = '0;
		k   = '0;
		for (int b = 0; b < BLOCK_W; b++) begin
			if (m[b]) begin
				if (k < COORD_W[$clog2(COORD_W+1)-1:0]) begin
					res[k] = v[b];
				end
				k = k + 1'b1;
			end
		end
		return res;
	endfunction

	always_comb begin
		bc  = start_image ? '0 : block_counter_q;
		z   = start_image ? '0 : row_in_block_q;
		hlt = start_image ? 1'b0 : halted_q;
		w   = image_width[SIDE_W-1:2];
		h   = image_height[SIDE_W-1:2];

		// first table row whose limit covers the block count
		blocks = data_length[LEN_W-1:6];
		found  = 1'b0;
		sel    = TABLE_IDX_W'(TABLE_SIZE - 1);
		for (int i = TABLE_ROWS - 1; i >= 0; i--) begin
			if (blocks <= BLK_LIMIT[i]) begin
				found = 1'b1;
				sel   = TABLE_IDX_W'(i);
			end
		end

		for (int i = 0; i < TABLE_SIZE; i++) begin
			xs[i] = gather(bc, X_MASK[i]);
			ys[i] = gather(bc, Y_MASK[i]);
		end
		x = xs[sel];
		y = ys[sel];

		fail = !found || (data_length == '0) || (bc >= BLK_LIMIT[sel]) ||
			({bc, 6'b0} >= data_length) ||
			(COL_W'(x) >= w) || (COL_W'(y) >= h);

		emit = !hlt && ((z != 2'd0) || !fail);

		hlt_next = hlt || ((z == 2'd0) && fail);
		bc_next  = bc;
		z_next   = z;
		if (emit) begin
			z_next = z + 2'd1;
			if (z == 2'd3) begin
				bc_next = bc + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_counter_q <= '0;
			row_in_block_q  <= '0;
			halted_q        <= 1'b0;
		end else if (take) begin
			block_counter_q <= bc_next;
			row_in_block_q  <= z_next;
			halted_q        <= hlt_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= take && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pos_s1  <= '{x: x, y: y, z: z, w: w};
			low_s1  <= row_low_half;
			high_s1 <= row_high_half;
		end
	end

endmodule

### rtl/bld_addr.sv
module bld_addr import bld_pkg::*; #(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              valid_s1,
	input  pos_t              pos_s1,
	input  logic [DATA_W-1:0] low_s1,
	input  logic [DATA_W-1:0] high_s1,
	output logic              out_valid,
	output logic [ADDR_W-1:0] dest_address,
	output logic [DATA_W-1:0] out_low_half,
	output logic [DATA_W-1:0] out_high_half
);

	logic [ROW_W-1:0]       pixel_row;
	logic [ROW_W+COL_W-1:0] prod;
	logic [ADDR_W-1:0]      addr;

	// address = (row * w * 16) + (x * 16) + header
	always_comb begin
		pixel_row = {pos_s1.y, pos_s1.z};
		prod      = pixel_row * pos_s1.w;
		addr      = ADDR_W'({prod, 4'b0}) + ADDR_W'({pos_s1.x, 4'b0}) +
			ADDR_W'(HEADER_BYTES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			dest_address  <= addr;
			out_low_half  <= low_s1;
			out_high_half <= high_s1;
		end
	end

endmodule

### rtl/block_linear_deswizzle_addr.sv
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  start_image, row_low_half, row_high_half
// out       output     out_valid/out_stall dest_address, out_low_half, out_high_half
// cfg       input      cfg_we             cfg_index, cfg_data
//
// One row per cycle while no stall holds the pipe; a result passes the stage-one
// registers and then the output registers before it is valid at the output.
// Stage one runs the block checks and counters, stage two the address multiply.
// arst_n clears counters, halt flag, valid bits and the config registers.
// out_stall holds both stages; in_stall rises only when every stage is full.
module block_linear_deswizzle_addr import bld_pkg::*; #(
	parameter int TABLE_ROWS   = TABLE_ROWS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 start_image,
	input  logic [DATA_W-1:0]    row_low_half,
	input  logic [DATA_W-1:0]    row_high_half,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ADDR_W-1:0]    dest_address,
	output logic [DATA_W-1:0]    out_low_half,
	output logic [DATA_W-1:0]    out_high_half,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [SIDE_W-1:0] image_width_q;
	logic [SIDE_W-1:0] image_height_q;
	logic [LEN_W-1:0]  data_length_q;

	logic              valid_s1;
	pos_t              pos_s1;
	logic [DATA_W-1:0] low_s1;
	logic [DATA_W-1:0] high_s1;
	logic              adv_out;
	logic              adv_s1;
	logic              take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= '0;
			image_height_q <= '0;
			data_length_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[SIDE_W-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[SIDE_W-1:0];
				CFG_DATA_LENGTH:  data_length_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// advance a stage when the one after it is empty or moving
	assign adv_out  = !out_valid || !out_stall;
	assign adv_s1   = !valid_s1 || adv_out;
	assign in_stall = !adv_s1;
	assign take     = in_valid && adv_s1;

	bld_pos #(
		.TABLE_ROWS (TABLE_ROWS)
	) u_pos (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.adv           (adv_s1),
		.start_image   (start_image),
		.row_low_half  (row_low_half),
		.row_high_half (row_high_half),
		.image_width   (image_width_q),
		.image_height  (image_height_q),
		.data_length   (data_length_q),
		.valid_s1      (valid_s1),
		.pos_s1        (pos_s1),
		.low_s1        (low_s1),
		.high_s1       (high_s1)
	);

	bld_addr #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_addr (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv_out),
		.valid_s1      (valid_s1),
		.pos_s1        (pos_s1),
		.low_s1        (low_s1),
		.high_s1       (high_s1),
		.out_valid     (out_valid),
		.dest_address  (dest_address),
		.out_low_half  (out_low_half),
		.out_high_half (out_high_half)
	);

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import bld_pkg::*;

	localparam int TBL_N          = 8;
	localparam int HDR_BYTES      = 12;
	localparam int HOLD_CYCLES    = 100;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int ROW_TARGET     = 1550;
	localparam int DIR_STEPS      = 27;

	localparam logic [BLOCK_W-1:0] BLOCK_CAP [TBL_N] = '{
		21'h000040, 21'h000100, 21'h000400, 21'h001000,
		21'h004000, 21'h010000, 21'h040000, 21'h100000
	};
	localparam logic [BLOCK_W-1:0] COL_PICK [TBL_N] = '{
		21'h000032, 21'h0000d2, 21'h000392, 21'h000f12,
		21'h003e12, 21'h007e12, 21'h00fe12, 21'h01fe12
	};
	localparam logic [BLOCK_W-1:0] ROW_PICK [TBL_N] = '{
		21'h00000d, 21'h00002d, 21'h00006d, 21'h0000ed,
		21'h0001ed, 21'h0081ed, 21'h0301ed, 21'h0e01ed
	};

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_ADDR
	} check_t;

	typedef enum logic {
		STEP_ROW,
		STEP_CFG
	} step_kind_t;

	typedef struct packed {
		step_kind_t          kind;
		logic                first;
		logic [DATA_W-1:0]   lo;
		logic [DATA_W-1:0]   hi;
		check_t              chk;
		logic [ADDR_W-1:0]   addr;
		logic [SIDE_W-1:0]   w;
		logic [SIDE_W-1:0]   h;
		logic [LEN_W-1:0]    len;
	} step_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
	} row_out_t;

	// Directed part: extremes, each stop condition and a config change inside a block.
	localparam step_t DIR_TABLE [DIR_STEPS] = '{
		'{STEP_ROW, 1'b1, 64'h0, 64'h0, CHK_NONE, 30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_CFG, 1'b0, 64'h0, 64'h0, CHK_MODEL, 30'd0, 14'd16383, 14'd16383, 27'h4000000},
		'{STEP_ROW, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, CHK_ADDR, 30'd12, 14'd0, 14'd0, 27'd0},
		'{STEP_ROW, 1'b0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, CHK_MODEL, 30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_ROW, 1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, CHK_MODEL,
			30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_ROW, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, CHK_MODEL,
			30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_ROW, 1'b0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, CHK_MODEL,
			30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_CFG, 1'b0, 64'h0, 64'h0, CHK_MODEL, 30'd0, 14'd32, 14'd32, 27'd64},
		'{STEP_ROW, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, CHK_ADDR,
			30'd12, 14'd0, 14'd0, 27'd0},
		'{STEP_ROW, 1'b0, 64'h1, 64'h2, CHK_MODEL, 30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_ROW, 1'b0, 64'h3, 64'h4, CHK_MODEL, 30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_ROW, 1'b0, 64'h5, 64'h6, CHK_MODEL, 30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_ROW, 1'b0, 64'h7, 64'h8, CHK_NONE, 30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_ROW, 1'b0, 64'h9, 64'hA, CHK_NONE, 30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_CFG, 1'b0, 64'h0, 64'h0, CHK_MODEL, 30'd0, 14'd32, 14'd32, 27'h7FFFFFF},
		'{STEP_ROW, 1'b1, 64'hB, 64'hC, CHK_NONE, 30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_CFG, 1'b0, 64'h0, 64'h0, CHK_MODEL, 30'd0, 14'd3, 14'd16383, 27'd4096},
		'{STEP_ROW, 1'b1, 64'hD, 64'hE, CHK_NONE, 30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_CFG, 1'b0, 64'h0, 64'h0, CHK_MODEL, 30'd0, 14'd16383, 14'd2, 27'd4096},
		'{STEP_ROW, 1'b1, 64'hF, 64'h10, CHK_NONE, 30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_CFG, 1'b0, 64'h0, 64'h0, CHK_MODEL, 30'd0, 14'd32, 14'd32, 27'd4096},
		'{STEP_ROW, 1'b1, 64'h11, 64'h12, CHK_MODEL, 30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_ROW, 1'b0, 64'h13, 64'h14, CHK_MODEL, 30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_CFG, 1'b0, 64'h0, 64'h0, CHK_MODEL, 30'd0, 14'd32, 14'd32, 27'h7FFFFFF},
		'{STEP_ROW, 1'b0, 64'h15, 64'h16, CHK_MODEL, 30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_ROW, 1'b0, 64'h17, 64'h18, CHK_MODEL, 30'd0, 14'd0, 14'd0, 27'd0},
		'{STEP_ROW, 1'b0, 64'h19, 64'h1A, CHK_NONE, 30'd0, 14'd0, 14'd0, 27'd0}
	};

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_stall;
	logic                 start_image   = 1'b0;
	logic [DATA_W-1:0]    row_low_half  = '0;
	logic [DATA_W-1:0]    row_high_half = '0;
	logic                 out_valid;
	logic                 out_stall     = 1'b0;
	logic [ADDR_W-1:0]    dest_address;
	logic [DATA_W-1:0]    out_low_half;
	logic [DATA_W-1:0]    out_high_half;
	logic                 cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = CFG_IMAGE_WIDTH;
	logic [CFG_W-1:0]     cfg_data      = '0;

	// travels with each offered row so the monitor sees it at the transfer edge
	check_t            row_check      = CHK_MODEL;
	logic [ADDR_W-1:0] row_check_addr = '0;

	bit no_idle  = 1'b0;
	bit hold_req = 1'b0;

	// predictor state
	logic [SIDE_W-1:0]  cfg_width  = '0;
	logic [SIDE_W-1:0]  cfg_height = '0;
	logic [LEN_W-1:0]   cfg_length = '0;
	logic [BLOCK_W-1:0] blk_idx    = '0;
	logic [1:0]         blk_row    = '0;
	logic               halted_flag = 1'b0;

	row_out_t    pending_rows [$];
	int unsigned live_rows = 0;
	int unsigned rows_seen = 0;
	int unsigned bad_rows  = 0;

	block_linear_deswizzle_addr i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.start_image   (start_image),
		.row_low_half  (row_low_half),
		.row_high_half (row_high_half),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.dest_address  (dest_address),
		.out_low_half  (out_low_half),
		.out_high_half (out_high_half),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Pack the bits of v selected by m toward bit 0.
	function automatic logic [BLOCK_W-1:0] pick_bits(logic [BLOCK_W-1:0] v,
			logic [BLOCK_W-1:0] m);
		logic [BLOCK_W-1:0] packed_bits;
		int                 k;
		packed_bits = '0;
		k = 0;
		for (int b = 0; b < BLOCK_W; b++) begin
			if (m[b]) begin
				packed_bits[k] = v[b];
				k++;
			end
		end
		return packed_bits;
	endfunction

	function automatic bit predict_row(input logic first, input logic [DATA_W-1:0] lo,
			input logic [DATA_W-1:0] hi, output row_out_t res);
		logic [BLOCK_W-1:0] blocks;
		logic [BLOCK_W-1:0] bx;
		logic [BLOCK_W-1:0] by;
		logic [COL_W-1:0]   cols;
		logic [COL_W-1:0]   rows;
		logic [63:0]        addr;
		int                 sel;
		res = '0;
		if (first) begin
			blk_idx = '0;
			blk_row = '0;
			halted_flag = 1'b0;
		end
		if (halted_flag)
			return 1'b0;
		cols = cfg_width[SIDE_W-1:2];
		rows = cfg_height[SIDE_W-1:2];
		blocks = cfg_length[LEN_W-1:6];
		sel = TBL_N;
		for (int r = TBL_N - 1; r >= 0; r--)
			if (blocks <= BLOCK_CAP[r])
				sel = r;
		if (sel == TBL_N) begin
			if (blk_row == 0) begin
				halted_flag = 1'b1;
				return 1'b0;
			end
			// length grew past the table inside a block: finish it on the last row
			sel = TBL_N - 1;
		end
		bx = pick_bits(blk_idx, COL_PICK[sel]);
		by = pick_bits(blk_idx, ROW_PICK[sel]);
		if (blk_row == 0 && (cfg_length == 0 || blk_idx >= BLOCK_CAP[sel] ||
				{blk_idx, 6'b0} >= cfg_length || bx >= cols || by >= rows)) begin
			halted_flag = 1'b1;
			return 1'b0;
		end
		addr = ((64'(by) * 4 + 64'(blk_row)) * 64'(cols) * 4 + 64'(bx) * 4) * 4 + HDR_BYTES;
		res.addr = addr[ADDR_W-1:0];
		res.lo = lo;
		res.hi = hi;
		blk_row = blk_row + 1'b1;
		if (blk_row == 0)
			blk_idx = blk_idx + 1'b1;
		return 1'b1;
	endfunction

	// Monitor: check results, track config writes, predict accepted rows.
	always @(posedge clk) begin
		row_out_t got;
		row_out_t want;
		bit       made;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{dest_address, out_low_half, out_high_half};
				rows_seen++;
				if (pending_rows.size() == 0) begin
					bad_rows++;
					if (bad_rows <= 10)
						$display("result %0d unexpected: address %h low %h high %h",
							rows_seen, got.addr, got.lo, got.hi);
				end else begin
					want = pending_rows.pop_front();
					if (got.addr !== want.addr || got.lo !== want.lo || got.hi !== want.hi) begin
						bad_rows++;
						if (bad_rows <= 10)
							$display("result %0d mismatch: address exp %h got %h,",
								rows_seen, want.addr, got.addr,
								" low exp %h got %h, high exp %h got %h",
								want.lo, got.lo, want.hi, got.hi);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  cfg_width  = cfg_data[SIDE_W-1:0];
					CFG_IMAGE_HEIGHT: cfg_height = cfg_data[SIDE_W-1:0];
					CFG_DATA_LENGTH:  cfg_length = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				live_rows++;
				made = predict_row(start_image, row_low_half, row_high_half, want);
				case (row_check)
					CHK_MODEL: begin
						if (made)
							pending_rows.push_back(want);
					end
					CHK_ADDR: begin
						pending_rows.push_back('{row_check_addr, row_low_half, row_high_half});
					end
					default: ;
				endcase
			end
		end
	end

	// Receiver: random stalls per transfer, one long hold on request.
	initial begin
		int unsigned pause;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				pause = no_idle ? 0 : $urandom_range(0, 18);
				if (pause != 0) begin
					out_stall <= 1'b1;
					repeat (pause) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_row(logic first, logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi,
			check_t chk, logic [ADDR_W-1:0] addr);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_image <= first;
		row_low_half <= lo;
		row_high_half <= hi;
		row_check <= chk;
		row_check_addr <= addr;
		do @(posedge clk); while (in_stall);
	endtask

	// Wait for every expected result, then for the pipe to empty of rows that give none.
	task automatic settle();
		int unsigned calm;
		in_valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		calm = 0;
		while (calm < 4) begin
			@(posedge clk);
			calm = out_stall ? 0 : calm + 1;
		end
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Upper data bits above a register's width are random and must be dropped.
	task automatic program_regs(logic [SIDE_W-1:0] w, logic [SIDE_W-1:0] h,
			logic [LEN_W-1:0] len, bit do_w, bit do_h, bit do_len);
		if (do_w)
			write_reg(CFG_IMAGE_WIDTH, {13'($urandom), w});
		if (do_h)
			write_reg(CFG_IMAGE_HEIGHT, {13'($urandom), h});
		if (do_len)
			write_reg(CFG_DATA_LENGTH, len);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned       mode;
		int unsigned       r;
		int unsigned       n;
		int unsigned       len_floor;
		logic [SIDE_W-1:0] w;
		logic [SIDE_W-1:0] h;
		logic [LEN_W-1:0]  len;
		bit                first;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TABLE[i]) begin
			if (DIR_TABLE[i].kind == STEP_CFG) begin
				settle();
				program_regs(DIR_TABLE[i].w, DIR_TABLE[i].h, DIR_TABLE[i].len, 1, 1, 1);
			end else begin
				send_row(DIR_TABLE[i].first, DIR_TABLE[i].lo, DIR_TABLE[i].hi,
					DIR_TABLE[i].chk, DIR_TABLE[i].addr);
			end
		end

		// Back-pressure: hold the output while rows keep coming.
		settle();
		program_regs(14'd64, 14'd64, 27'd4096, 1, 1, 1);
		no_idle = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < 120; i++)
			send_row(i == 0, {$urandom, $urandom}, {$urandom, $urandom}, CHK_MODEL, '0);
		no_idle = 1'b0;

		while (live_rows < ROW_TARGET) begin
			settle();
			mode = $urandom_range(0, 9);
			w = 14'($urandom_range(0, 16383));
			h = 14'($urandom_range(0, 16383));
			len = 27'($urandom);
			if (mode < 6) begin
				// well-formed image: dimensions and length that let blocks flow
				w = 14'(4 * (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) :
					$urandom_range(8, 64)) + $urandom_range(0, 3));
				h = 14'(4 * (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) :
					$urandom_range(8, 64)) + $urandom_range(0, 3));
				r = ($urandom_range(0, 3) == 0) ? $urandom_range(1, TBL_N - 1) : 0;
				len_floor = (r == 0) ? 1 : (BLOCK_CAP[r - 1] + 1) * 64;
				len = 27'($urandom_range(BLOCK_CAP[r] * 64 + 63, len_floor));
				program_regs(w, h, len, 1, 1, 1);
			end else if (mode == 6) begin
				program_regs(w, h, len, 1, 1, 1);
			end else if (mode == 7) begin
				len = ($urandom_range(0, 1) == 0) ? '0 :
					27'($urandom_range(27'h7FFFFFF, 27'h4000040));
				program_regs(w, h, len, 0, 0, 1);
			end else begin
				program_regs(w, h, len, $urandom_range(0, 1), $urandom_range(0, 1),
					$urandom_range(0, 1));
			end
			no_idle = ($urandom_range(0, 4) == 0);
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(250, 300) : $urandom_range(8, 100);
			for (int i = 0; i < n; i++) begin
				first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 59) == 0);
				send_row(first, {$urandom, $urandom}, {$urandom, $urandom}, CHK_MODEL, '0);
			end
		end
		no_idle = 1'b0;

		settle();
		repeat (8) @(posedge clk);
		if (bad_rows == 0 && pending_rows.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
